@@ hdl/lwfd_pkg.sv @@
// Package of shared types, codes and sizes for the lock wait-for deadlock detector.
`default_nettype none
package lwfd_pkg;

  localparam int MAX_THREADS_DEF = 16;
  localparam int MAX_LOCKS_DEF   = 16;
  localparam int WAIT_W          = 5;
  localparam logic [WAIT_W-1:0] WAITERS_MAX = 5'd31;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic [1:0] REQ_LOCK    = 2'd0;
  localparam logic [1:0] REQ_ACQUIRE = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  typedef enum logic [1:0] {
    OP_REQ,
    OP_ACQ,
    OP_REL,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ROOT,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] thread_id;
    logic [47:0] lock_addr;
  } in_item_t;

  typedef struct packed {
    logic        deadlock;
    logic [31:0] cycle_thread;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] thread_id;
    logic [47:0] lock_addr;
  } q_item_t;

endpackage
`default_nettype wire

@@ hdl/lock_wait_for_deadlock_detector_top.sv @@
// Top level of the lock wait-for deadlock detector: front queue and back-end engine.
//
// Usage: lock events enter on the in_ channel (in_valid, in_stall, in_data) and one
// result per event leaves on the out_ channel (out_valid, out_stall, out_data). A
// transfer happens at a rising edge where valid is high and stall is low.
// The front end decodes each event and places it in a two-entry queue, so the
// sender can hand over up to two events while the back end is still busy.
// The back end first applies the event to the tables (S_EXEC), then walks the wait-for
// graph depth first, trying one root at a time (S_ROOT) and following one edge or
// leaving one vertex per step (S_SCAN); the search loop, not the table update, sets
// the time an event takes. Events are processed one at a time, in order.
// Reset (rst_n low at a clock edge) empties the queue, the thread and lock tables
// and the wait-for matrix at once; no clearing pass is needed.
// While the receiver stalls, the finished result is held in the output register;
// the back end waits before writing the next one, and once the queue fills the
// input channel stalls in turn.
`default_nettype none
module lock_wait_for_deadlock_detector_top #(
  parameter int MAX_THREADS = lwfd_pkg::MAX_THREADS_DEF,
  parameter int MAX_LOCKS   = lwfd_pkg::MAX_LOCKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lwfd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lwfd_pkg::out_item_t      out_data
);

  // Queue interface between the two halves.
  logic              q_valid;
  lwfd_pkg::q_item_t q_data;
  logic              q_pop;

  lwfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  lwfd_back #(
    .MAX_THREADS (MAX_THREADS),
    .MAX_LOCKS   (MAX_LOCKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ hdl/lwfd_front.sv @@
// Front end: decodes each event and holds it in a short queue for the back end.
`default_nettype none
module lwfd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lwfd_pkg::in_item_t in_data,
  output logic                    q_valid,
  output lwfd_pkg::q_item_t       q_data,
  input  wire logic               q_pop
);

  localparam int DEPTH = lwfd_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  lwfd_pkg::q_item_t mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r;
  logic [AW-1:0]     rd_ptr_r;
  logic [AW:0]       cnt_r;
  lwfd_pkg::q_item_t dec;
  logic              push;
  logic              pop;

  always_comb begin
    dec.thread_id = in_data.thread_id;
    dec.lock_addr = in_data.lock_addr;
    unique case (in_data.req_type)
      lwfd_pkg::REQ_LOCK:    dec.op = lwfd_pkg::OP_REQ;
      lwfd_pkg::REQ_ACQUIRE: dec.op = lwfd_pkg::OP_ACQ;
      lwfd_pkg::REQ_RELEASE: dec.op = lwfd_pkg::OP_REL;
      default:               dec.op = lwfd_pkg::OP_NOP;
    endcase
  end

  assign in_stall = (cnt_r == (AW+1)'(DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_data   = mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

@@ hdl/lwfd_back.sv @@
// Back end: applies an event to the tables and runs the cycle search over the wait-for graph.
`default_nettype none
module lwfd_back #(
  parameter int MAX_THREADS = lwfd_pkg::MAX_THREADS_DEF,
  parameter int MAX_LOCKS   = lwfd_pkg::MAX_LOCKS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire lwfd_pkg::q_item_t q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lwfd_pkg::out_item_t    out_data
);

  localparam int NT = MAX_THREADS;
  localparam int NL = MAX_LOCKS;
  localparam int TW = $clog2(NT);
  localparam int LW = $clog2(NL);
  localparam int WW = lwfd_pkg::WAIT_W;

  logic [31:0]        thr_id_r   [NT];
  logic [NT-1:0]      thr_vld_r;
  logic [47:0]        lk_addr_r  [NL];
  logic [NL-1:0]      lk_vld_r;
  logic [TW-1:0]      lk_hold_r  [NL];
  logic [WW-1:0]      lk_wait_r  [NL];
  logic [NT-1:0]      wm_r       [NT];
  logic [NT-1:0]      rem_r      [NT];
  logic [TW-1:0]      stk_r      [NT];
  logic [NT-1:0]      reach_r;
  logic [NT-1:0]      path_r;
  logic [TW:0]        sp_r;
  logic [TW-1:0]      fslot_r;
  logic               found_r;
  logic [1:0]         status_r;
  lwfd_pkg::q_item_t  item_r;
  lwfd_pkg::state_t   state_r, state_nxt;
  logic               out_vld_r;
  lwfd_pkg::out_item_t out_r;

  // Table look-ups for the event being executed.
  logic               lk_hit;
  logic [LW-1:0]      lk_idx;
  logic               lk_free_any;
  logic [LW-1:0]      lk_free;
  logic               th_hit;
  logic [TW-1:0]      th_idx;
  logic               th_free_any;
  logic [TW-1:0]      th_free;
  logic               t_ok;
  logic [TW-1:0]      t_idx;
  logic [TW-1:0]      hold;
  logic [NT-1:0]      row_base;
  logic               need_thread;
  logic [1:0]         exec_status;

  // Search helpers.
  logic [NT-1:0]      roots;
  logic [TW-1:0]      root_idx;
  logic [TW-1:0]      top;
  logic [NT-1:0]      cand;
  logic [TW-1:0]      v_idx;

  always_comb begin
    lk_hit      = 1'b0;
    lk_idx      = '0;
    lk_free_any = 1'b0;
    lk_free     = '0;
    for (int i = NL-1; i >= 0; i--) begin
      if (lk_vld_r[i] && lk_addr_r[i] == item_r.lock_addr) begin
        lk_hit = 1'b1;
        lk_idx = LW'(i);
      end
      if (!lk_vld_r[i]) begin
        lk_free_any = 1'b1;
        lk_free     = LW'(i);
      end
    end
    th_hit      = 1'b0;
    th_idx      = '0;
    th_free_any = 1'b0;
    th_free     = '0;
    for (int i = NT-1; i >= 0; i--) begin
      if (thr_vld_r[i] && thr_id_r[i] == item_r.thread_id) begin
        th_hit = 1'b1;
        th_idx = TW'(i);
      end
      if (!thr_vld_r[i]) begin
        th_free_any = 1'b1;
        th_free     = TW'(i);
      end
    end
    t_ok        = th_hit || th_free_any;
    t_idx       = th_hit ? th_idx : th_free;
    hold        = lk_hold_r[lk_idx];
    row_base    = th_hit ? wm_r[th_idx] : '0;
    need_thread = (item_r.op == lwfd_pkg::OP_ACQ) ||
                  ((item_r.op == lwfd_pkg::OP_REQ) && lk_hit);
    // Outcome code of the event, decided from the tables before it is applied.
    if ((item_r.op == lwfd_pkg::OP_REQ) && lk_hit && !t_ok) begin
      exec_status = lwfd_pkg::STATUS_FULL;
    end else if ((item_r.op == lwfd_pkg::OP_ACQ) && (!t_ok || (!lk_hit && !lk_free_any))) begin
      exec_status = lwfd_pkg::STATUS_FULL;
    end else if ((item_r.op == lwfd_pkg::OP_REL) && !lk_hit) begin
      exec_status = lwfd_pkg::STATUS_UNKNOWN;
    end else begin
      exec_status = lwfd_pkg::STATUS_OK;
    end
  end

  always_comb begin
    roots    = thr_vld_r & ~reach_r;
    root_idx = '0;
    for (int i = NT-1; i >= 0; i--) begin
      if (roots[i]) root_idx = TW'(i);
    end
    top   = stk_r[TW'(sp_r - 1'b1)];
    cand  = rem_r[top] & (path_r | ~reach_r);
    v_idx = '0;
    for (int i = NT-1; i >= 0; i--) begin
      if (cand[i]) v_idx = TW'(i);
    end
  end

  assign q_pop = (state_r == lwfd_pkg::S_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lwfd_pkg::S_IDLE: if (q_valid) state_nxt = lwfd_pkg::S_EXEC;
      lwfd_pkg::S_EXEC: state_nxt = lwfd_pkg::S_ROOT;
      lwfd_pkg::S_ROOT: state_nxt = (roots != '0) ? lwfd_pkg::S_SCAN : lwfd_pkg::S_FIN;
      lwfd_pkg::S_SCAN: begin
        if (cand != '0) begin
          if (path_r[v_idx]) state_nxt = lwfd_pkg::S_FIN;
        end else if (sp_r == (TW+1)'(1)) begin
          state_nxt = lwfd_pkg::S_ROOT;
        end
      end
      lwfd_pkg::S_FIN: if (!out_vld_r || !out_stall) state_nxt = lwfd_pkg::S_IDLE;
      default: state_nxt = lwfd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lwfd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload side of the tables and the search stack.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_data;
    end
    unique case (state_r)
      lwfd_pkg::S_EXEC: begin
        status_r <= exec_status;
        found_r  <= 1'b0;
        if (need_thread && !th_hit && th_free_any) begin
          thr_id_r[th_free] <= item_r.thread_id;
        end
        unique case (item_r.op)
          lwfd_pkg::OP_REQ: begin
            if (lk_hit && t_ok && lk_wait_r[lk_idx] < lwfd_pkg::WAITERS_MAX) begin
              lk_wait_r[lk_idx] <= lk_wait_r[lk_idx] + 1'b1;
            end
          end
          lwfd_pkg::OP_ACQ: begin
            if (t_ok) begin
              if (!lk_hit) begin
                if (lk_free_any) begin
                  lk_addr_r[lk_free] <= item_r.lock_addr;
                  lk_hold_r[lk_free] <= t_idx;
                  lk_wait_r[lk_free] <= '0;
                end
              end else begin
                if (lk_wait_r[lk_idx] != '0) lk_wait_r[lk_idx] <= lk_wait_r[lk_idx] - 1'b1;
                lk_hold_r[lk_idx] <= t_idx;
              end
            end
          end
          default: ;
        endcase
      end
      lwfd_pkg::S_ROOT: begin
        if (roots != '0) begin
          stk_r[0]        <= root_idx;
          rem_r[root_idx] <= wm_r[root_idx];
        end
      end
      lwfd_pkg::S_SCAN: begin
        if (cand != '0) begin
          rem_r[top][v_idx] <= 1'b0;
          if (path_r[v_idx]) begin
            found_r <= 1'b1;
            fslot_r <= v_idx;
          end else begin
            stk_r[TW'(sp_r)] <= v_idx;
            rem_r[v_idx]     <= wm_r[v_idx];
          end
        end
      end
      default: ;
    endcase
  end

  // Control side: valid bits, wait-for matrix, search masks and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_vld_r <= '0;
      lk_vld_r  <= '0;
      reach_r   <= '0;
      path_r    <= '0;
      sp_r      <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < NT; i++) wm_r[i] <= '0;
    end else begin
      if (state_r == lwfd_pkg::S_FIN && (!out_vld_r || !out_stall)) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        lwfd_pkg::S_EXEC: begin
          reach_r <= '0;
          path_r  <= '0;
          if (need_thread && !th_hit && th_free_any) thr_vld_r[th_free] <= 1'b1;
          if (need_thread && t_ok) begin
            if (item_r.op == lwfd_pkg::OP_REQ) begin
              wm_r[t_idx] <= row_base | (NT'(1) << hold);
            end else if (lk_hit) begin
              wm_r[t_idx] <= row_base & ~(NT'(1) << hold);
            end else begin
              wm_r[t_idx] <= row_base;
            end
          end
          if (item_r.op == lwfd_pkg::OP_ACQ && t_ok && !lk_hit && lk_free_any) begin
            lk_vld_r[lk_free] <= 1'b1;
          end
          if (item_r.op == lwfd_pkg::OP_REL && lk_hit && lk_wait_r[lk_idx] == '0) begin
            lk_vld_r[lk_idx] <= 1'b0;
          end
        end
        lwfd_pkg::S_ROOT: begin
          if (roots != '0) begin
            reach_r[root_idx] <= 1'b1;
            path_r            <= NT'(1) << root_idx;
            sp_r              <= (TW+1)'(1);
          end
        end
        lwfd_pkg::S_SCAN: begin
          if (cand != '0) begin
            if (!path_r[v_idx]) begin
              reach_r[v_idx] <= 1'b1;
              path_r[v_idx]  <= 1'b1;
              sp_r           <= sp_r + 1'b1;
            end
          end else begin
            path_r[top] <= 1'b0;
            sp_r        <= sp_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lwfd_pkg::S_FIN && (!out_vld_r || !out_stall)) begin
      out_r.deadlock     <= found_r;
      out_r.cycle_thread <= found_r ? thr_id_r[fslot_r] : 32'd0;
      out_r.status       <= status_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
